FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication form of the check above
`define ASSERT_IMPLY(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/heq_pkg.sv
`default_nettype none

package heq_pkg;

    localparam int BINS       = 256;
    localparam int BIN_W      = $clog2(BINS);
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 23;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = CNT_W + 1;
    localparam int Q_W        = 8;
    localparam int STEP_W     = $clog2(Q_W);

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(4194304);
    localparam logic [BIN_W-1:0] LAST_BIN   = BIN_W'(BINS - 1);

    typedef enum logic [0:0] {
        OP_COUNT = 1'b0,
        OP_MAP   = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_WR,
        S_MAP,
        S_B_RD,
        S_B_ACC,
        S_B_LOAD,
        S_B_DIV
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

FILE: rtl/heq_divider.sv
`default_nettype none

module heq_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [heq_pkg::NUM_W-1:0]    numer,
    input  wire logic [heq_pkg::DEN_W-1:0]    denom,
    output heq_pkg::div_sts_t                 sts,
    output logic      [heq_pkg::Q_W-1:0]      quotient
);

    localparam int PAD_W = heq_pkg::NUM_W - heq_pkg::DEN_W - (heq_pkg::Q_W - 1);

    logic [heq_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [heq_pkg::NUM_W-1:0]  dsh_reg, dsh_next;
    logic [heq_pkg::Q_W-1:0]    q_reg, q_next;
    logic [heq_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       fits;

    // restoring division, one quotient bit per cycle, msb first
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer;
            dsh_next  = {{PAD_W{1'b0}}, denom, {(heq_pkg::Q_W - 1){1'b0}}};
            q_next    = '0;
            step_next = heq_pkg::STEP_W'(heq_pkg::Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next    = {q_reg[heq_pkg::Q_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: rtl/histogram_equalizer.sv
`default_nettype none

// Two-pass 8-bit grayscale histogram equalizer. A count transfer (op = 0)
// adds the pixel to a 256-bin histogram and bumps the frame pixel count;
// pixels beyond 4194304 in one frame are dropped. A count transfer with
// last set starts the table build, which walks the bins once, keeps a
// running cumulative sum and sets each table entry to
// floor((510*cum + N) / (2*N)), N being the frame pixel count, that is
// 255*cum/N rounded half up. The build also clears the histogram and the
// count. A map transfer (op = 1) returns the table entry for its pixel on
// pixel_out; a count transfer returns nothing. Every count or map transfer
// occupies the block for one histogram read-modify-write or one table read,
// both through memories with separate read and write addresses and
// registered read data. The table build handles the bins one after another,
// paced by the single 8-step restoring divider that computes each entry.
// After reset the block clears both memories, one entry per cycle, before
// it takes its first transfer. A finished map result sits in an output
// register, so the block goes on taking count transfers while it waits for
// the downstream side.

module histogram_equalizer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        op,
    input  wire logic [heq_pkg::PIX_W-1:0]   pixel,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [heq_pkg::PIX_W-1:0]   pixel_out
);

    `include "assert_macros.svh"

    heq_pkg::state_t state_reg, state_next;

    // histogram and equalization table
    logic [heq_pkg::CNT_W-1:0] bin_mem [heq_pkg::BINS];
    logic [heq_pkg::PIX_W-1:0] map_mem [heq_pkg::BINS];

    logic [heq_pkg::CNT_W-1:0] bin_rdata_reg;
    logic [heq_pkg::PIX_W-1:0] map_rdata_reg;
    logic [heq_pkg::BIN_W-1:0] bin_raddr, bin_waddr;
    logic [heq_pkg::BIN_W-1:0] map_raddr;
    logic [heq_pkg::CNT_W-1:0] bin_wdata;
    logic [heq_pkg::PIX_W-1:0] map_wdata;
    logic                      bin_we, map_we;

    // sequencer registers
    logic [heq_pkg::BIN_W-1:0] g_reg, g_next;
    logic [heq_pkg::CNT_W-1:0] cum_reg, cum_next;
    logic [heq_pkg::CNT_W-1:0] total_reg, total_next;
    logic [heq_pkg::BIN_W-1:0] px_reg, px_next;
    logic                      last_reg, last_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [heq_pkg::PIX_W-1:0] pixel_out_reg, pixel_out_next;
    logic                      out_load;

    // divider for the table build
    logic                         div_start;
    logic [heq_pkg::NUM_W-1:0]    div_numer;
    logic [heq_pkg::DEN_W-1:0]    div_denom;
    heq_pkg::div_sts_t            div_sts;
    logic [heq_pkg::Q_W-1:0]      div_q;

    logic in_xfer;
    logic room;
    logic out_free;

    assign in_xfer  = in_valid && !in_stall;
    assign room     = (total_reg < heq_pkg::MAX_PIXELS);
    assign out_free = !out_valid_reg || !out_stall;

    // numerator 510*cum + N, denominator 2*N
    assign div_numer = heq_pkg::NUM_W'({cum_reg, 9'b0})
                     - ({{(heq_pkg::NUM_W - heq_pkg::CNT_W - 1){1'b0}}, cum_reg, 1'b0})
                     + heq_pkg::NUM_W'(total_reg);
    assign div_denom = {total_reg, 1'b0};

    heq_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .sts      (div_sts),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            heq_pkg::S_CLEAR:
            begin
                if (g_reg == heq_pkg::LAST_BIN)
                begin
                    state_next = heq_pkg::S_IDLE;
                end
            end
            heq_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (op == heq_pkg::OP_MAP) ? heq_pkg::S_MAP
                                                         : heq_pkg::S_CNT_WR;
                end
            end
            heq_pkg::S_CNT_WR:
            begin
                state_next = last_reg ? heq_pkg::S_B_RD : heq_pkg::S_IDLE;
            end
            heq_pkg::S_MAP:
            begin
                if (out_free)
                begin
                    state_next = heq_pkg::S_IDLE;
                end
            end
            heq_pkg::S_B_RD:   state_next = heq_pkg::S_B_ACC;
            heq_pkg::S_B_ACC:  state_next = heq_pkg::S_B_LOAD;
            heq_pkg::S_B_LOAD: state_next = heq_pkg::S_B_DIV;
            heq_pkg::S_B_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = (g_reg == heq_pkg::LAST_BIN) ? heq_pkg::S_IDLE
                                                              : heq_pkg::S_B_RD;
                end
            end
            default:           state_next = heq_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        in_stall       = 1'b1;
        bin_raddr      = g_reg;
        map_raddr      = px_reg;
        bin_waddr      = g_reg;
        bin_wdata      = '0;
        bin_we         = 1'b0;
        map_wdata      = '0;
        map_we         = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        g_next         = g_reg;
        cum_next       = cum_reg;
        total_next     = total_reg;
        px_next        = px_reg;
        last_next      = last_reg;
        unique case (state_reg)
            heq_pkg::S_CLEAR:
            begin
                bin_we = 1'b1;
                map_we = 1'b1;
                g_next = g_reg + 1'b1;
            end
            heq_pkg::S_IDLE:
            begin
                in_stall  = 1'b0;
                bin_raddr = pixel;
                map_raddr = pixel;
                if (in_xfer)
                begin
                    px_next   = pixel;
                    last_next = last;
                end
            end
            heq_pkg::S_CNT_WR:
            begin
                bin_waddr = px_reg;
                bin_wdata = bin_rdata_reg + 1'b1;
                if (room)
                begin
                    bin_we     = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                if (last_reg)
                begin
                    g_next   = '0;
                    cum_next = '0;
                end
            end
            heq_pkg::S_MAP:
            begin
                out_load = out_free;
            end
            heq_pkg::S_B_RD:
            begin
            end
            heq_pkg::S_B_ACC:
            begin
                // take the bin into the running sum and clear it for the next frame
                cum_next = cum_reg + bin_rdata_reg;
                bin_we   = 1'b1;
            end
            heq_pkg::S_B_LOAD:
            begin
                div_start = 1'b1;
            end
            heq_pkg::S_B_DIV:
            begin
                if (div_sts.done)
                begin
                    map_we    = 1'b1;
                    map_wdata = (total_reg == '0) ? '0 : div_q;
                    g_next    = g_reg + 1'b1;
                    if (g_reg == heq_pkg::LAST_BIN)
                    begin
                        total_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pixel_out_next = pixel_out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            pixel_out_next = map_rdata_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= heq_pkg::S_CLEAR;
            g_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g_reg         <= g_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cum_reg       <= cum_next;
        px_reg        <= px_next;
        last_reg      <= last_next;
        pixel_out_reg <= pixel_out_next;
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[bin_raddr];
    end

    // table memory, written at the sweep index only
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[g_reg] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    `ASSERT_CLK(a_total_bound, total_reg <= heq_pkg::MAX_PIXELS, "pixel count past frame limit")
    `ASSERT_IMPLY(a_cum_bound, state_reg == heq_pkg::S_B_LOAD, (cum_reg <= total_reg) && !div_sts.busy, "running sum past pixel count")
    `ASSERT_IMPLY(a_div_owner, div_sts.done, state_reg == heq_pkg::S_B_DIV, "divider result outside table build")
    `ASSERT_CLK(a_build_end, (state_reg == heq_pkg::S_B_DIV) && div_sts.done && (g_reg == heq_pkg::LAST_BIN) |=> (total_reg == '0) && (state_reg == heq_pkg::S_IDLE), "count not cleared after build")
    `ASSERT_IMPLY(a_no_overwrite, out_load, !out_valid_reg || !out_stall, "held result overwritten")

endmodule

`default_nettype wire

FILE: test/tb_histogram_equalizer.sv
`default_nettype none

module tb_histogram_equalizer;

    timeunit 1ns;
    timeprecision 1ps;

    // random part size and the no-transfer watchdog limit
    localparam int RANDOM_ITEMS = 1830;
    localparam int STALL_LIMIT  = 16000;
    localparam int END_CYCLES   = 3400;

    // one pending input transfer; drain holds it back until all results are in
    typedef struct {
        heq_pkg::op_t              op;
        logic [heq_pkg::PIX_W-1:0] pixel;
        logic                      last;
        bit                        drain;
    } pix_item_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      op        = heq_pkg::OP_COUNT;
    logic [heq_pkg::PIX_W-1:0] pixel     = '0;
    logic                      last      = 1'b0;
    logic                      out_stall = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic [heq_pkg::PIX_W-1:0] pixel_out;

    // inputs still to be driven, equalized pixels still to arrive
    pix_item_t                 pixel_queue[$];
    logic [heq_pkg::PIX_W-1:0] expected_pix[$];

    // predictor state: histogram, frame pixel count, equalization table
    logic [heq_pkg::CNT_W-1:0] bin_cnt[heq_pkg::BINS];
    logic [heq_pkg::CNT_W-1:0] frame_total;
    logic [heq_pkg::PIX_W-1:0] eq_table[heq_pkg::BINS];

    // sampled at the rising edge: input transfer happened on the last edge
    logic in_taken = 1'b0;

    int burst_left  = 1;
    int gap_left    = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int n_counts    = 0;
    int n_maps      = 0;
    int n_builds    = 0;
    int n_checked   = 0;

    histogram_equalizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .pixel     (pixel),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cumulative sum over the bins, each entry 255*cum/N rounded half up,
    // then the histogram and count start over for the next frame
    task automatic rebuild_eq_table();
        logic [63:0] running;
        logic [63:0] quot;
        running = '0;
        for (int b = 0; b < heq_pkg::BINS; b++)
        begin
            running = running + 64'(bin_cnt[b]);
            if (frame_total == '0)
            begin
                eq_table[b] = '0;
            end
            else
            begin
                quot = (64'd510 * running + 64'(frame_total)) / (64'd2 * 64'(frame_total));
                eq_table[b] = (quot > 64'd255) ? 8'd255 : quot[heq_pkg::PIX_W-1:0];
            end
        end
        for (int b = 0; b < heq_pkg::BINS; b++)
        begin
            bin_cnt[b] = '0;
        end
        frame_total = '0;
        n_builds++;
    endtask

    // advance the predictor by one accepted input transfer
    task automatic equalize_predict(input heq_pkg::op_t item_op,
                                    input logic [heq_pkg::PIX_W-1:0] px,
                                    input logic lst);
        if (item_op == heq_pkg::OP_MAP)
        begin
            // map transfers read the table, last is ignored
            expected_pix.push_back(eq_table[px]);
            n_maps++;
        end
        else
        begin
            // count pixels beyond the frame limit are dropped, last still builds
            if (frame_total < heq_pkg::MAX_PIXELS)
            begin
                bin_cnt[px] = bin_cnt[px] + 1'b1;
                frame_total = frame_total + 1'b1;
            end
            n_counts++;
            if (lst)
            begin
                rebuild_eq_table();
            end
        end
    endtask

    task automatic queue_pixel(input heq_pkg::op_t item_op, input int px, input logic lst,
                               input bit drn = 1'b0);
        pix_item_t it;
        it.op    = item_op;
        it.pixel = px[heq_pkg::PIX_W-1:0];
        it.last  = lst;
        it.drain = drn;
        pixel_queue.push_back(it);
    endtask

    // input driver: bursts of transfers with random gaps, changes on the falling edge
    always @(negedge clk)
    begin : drive_proc
        pix_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken)
        begin
            // stalled transfer: valid and payload stay put
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pixel_queue.size() == 0 ||
                 (pixel_queue[0].drain && expected_pix.size() != 0))
        begin
            // out of items, or holding off until every result is back
            in_valid <= 1'b0;
        end
        else
        begin
            nxt = pixel_queue.pop_front();
            in_valid <= 1'b1;
            op       <= nxt.op;
            pixel    <= nxt.pixel;
            last     <= nxt.last;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                case ($urandom_range(0, 7))
                    0, 1, 2: gap_left <= 0;
                    7:       gap_left <= $urandom_range(20, 60);
                    default: gap_left <= $urandom_range(1, 5);
                endcase
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // downstream stall: modes of random length, from never stalled to long stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= (stall_left % 4 == 0);
            default: out_stall <= (stall_left % 32 >= 24);
        endcase
    end

    // monitor: results checked against the oldest expectation, inputs fed
    // to the predictor, watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin : check_proc
        logic [heq_pkg::PIX_W-1:0] want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_pix.size() == 0)
                begin
                    $display("%0t: unexpected pixel_out transfer: expected none, actual %0d",
                             $time, pixel_out);
                    errors++;
                end
                else
                begin
                    want = expected_pix.pop_front();
                    n_checked++;
                    if (pixel_out !== want)
                    begin
                        $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                                 $time, want, pixel_out);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                equalize_predict(heq_pkg::op_t'(op), pixel, last);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stim_proc
        int made;
        int frame_len;
        int map_len;
        int style;
        int lo;
        int px;
        for (int b = 0; b < heq_pkg::BINS; b++)
        begin
            bin_cnt[b]  = '0;
            eq_table[b] = '0;
        end
        frame_total = '0;

        // map before any build: table still all zero, last ignored on map
        queue_pixel(heq_pkg::OP_MAP, 0, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 255, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 128, 1'b0);
        // small frame with the extreme values and alternating bit patterns
        queue_pixel(heq_pkg::OP_COUNT, 0, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 255, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 8'h55, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 8'hAA, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 255, 1'b1);
        // first map waits for the build and the queue to empty
        queue_pixel(heq_pkg::OP_MAP, 0, 1'b0, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 255, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 8'h55, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 8'hAA, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 1, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 254, 1'b0);
        // one-pixel frames: every entry from that bin on goes to full scale
        queue_pixel(heq_pkg::OP_COUNT, 0, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 0, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 255, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 255, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 0, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 254, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 255, 1'b1);
        // map interleaved with counting still sees the old table
        queue_pixel(heq_pkg::OP_COUNT, 7, 1'b0);
        queue_pixel(heq_pkg::OP_MAP, 7, 1'b0);
        queue_pixel(heq_pkg::OP_COUNT, 7, 1'b1);
        queue_pixel(heq_pkg::OP_MAP, 7, 1'b0);

        // random frames: mostly a clean count pass then a map pass,
        // sometimes noise maps inside the count pass or no map pass at all
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(150, 400)
                                                     : $urandom_range(1, 48);
            if (frame_len > RANDOM_ITEMS - made)
            begin
                frame_len = RANDOM_ITEMS - made;
            end
            style = $urandom_range(0, 3);
            lo    = $urandom_range(0, 255);
            for (int i = 0; i < frame_len; i++)
            begin
                case (style)
                    0:       px = $urandom_range(0, 255);
                    1:       px = (lo + $urandom_range(0, 15) > 255) ? 255
                                                                     : lo + $urandom_range(0, 15);
                    2:       px = lo;
                    default: px = $urandom_range(0, 1) ? lo : 255 - lo;
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    queue_pixel(heq_pkg::OP_MAP, $urandom_range(0, 255),
                                1'($urandom_range(0, 1)));
                    made++;
                end
                queue_pixel(heq_pkg::OP_COUNT, px, i == frame_len - 1,
                            i == 0 && $urandom_range(0, 7) == 0);
                made++;
            end
            map_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
            if (map_len > RANDOM_ITEMS - made)
            begin
                map_len = RANDOM_ITEMS - made;
            end
            for (int i = 0; i < map_len; i++)
            begin
                queue_pixel(heq_pkg::OP_MAP, $urandom_range(0, 255),
                            1'($urandom_range(0, 1)));
                made++;
            end
        end

        // reset once, released on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pixel_queue.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_pix.size() != 0)
        begin
            @(posedge clk);
        end
        // let a trailing table build finish and catch any stray result
        repeat (END_CYCLES) @(posedge clk);

        $display("run covered %0d count and %0d map transfers over %0d table builds",
                 n_counts, n_maps, n_builds);
        $display("%0d equalized pixels checked, %0d mismatches", n_checked, errors);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
